FILE: rtl/core/assert_macros.svh
// Assertion macros used by the decoder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define APPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define APPM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/appm_pkg.sv
// Types, codes and constants shared by the ASCII P3 decoder modules.
package appm_pkg;

   // Default coordinate counter width.
   localparam int CoordBitsDefault = 16;

   // Characters the parser recognizes.
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharHash    = 8'h23;
   localparam logic [7:0] CharP       = 8'h50;
   localparam logic [7:0] CharThree   = 8'h33;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;

   // Numeric limits.
   localparam logic [15:0] AccumMax  = 16'hFFFF;
   localparam logic [7:0]  SampleMax = 8'hFF;
   localparam logic [1:0]  ChannelLast = 2'd2;

   // Result kinds.
   localparam logic [1:0] KindWidth  = 2'd0;
   localparam logic [1:0] KindHeight = 2'd1;
   localparam logic [1:0] KindMaxval = 2'd2;
   localparam logic [1:0] KindSample = 2'd3;

   // Magic token status.
   localparam logic [1:0] MagicUnseen   = 2'd0;
   localparam logic [1:0] MagicAccepted = 2'd1;
   localparam logic [1:0] MagicRejected = 2'd2;

   // Magic token match position.
   localparam logic [1:0] PosNone     = 2'd0;
   localparam logic [1:0] PosP        = 2'd1;
   localparam logic [1:0] PosP3       = 2'd2;
   localparam logic [1:0] PosMismatch = 2'd3;

   // Sample divider: one quotient bit per step, bit 8 flags saturation.
   localparam int DivSteps     = 9;
   localparam int DivCountBits = $clog2(DivSteps);
   localparam int DivBits      = 24;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] header_value;
      logic [15:0] row;
      logic [15:0] column;
      logic [1:0]  channel;
      logic [7:0]  sample;
      logic        image_full;
      logic        overflow_drop;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      StIdle,
      StDivide
   } ctl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic div_run;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic result;
      logic divide;
      logic div_last;
   } dp_status_type;

endpackage

FILE: rtl/core/appm_datapath.sv
// Parser state, header and pixel counters, sample divider and result register.
module appm_datapath #(
   parameter int COORD_BITS = appm_pkg::CoordBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  appm_pkg::req_payload_type req_data,
   input  appm_pkg::ctl_cmd_type     cmd,
   output appm_pkg::dp_status_type   status,
   output appm_pkg::rsp_payload_type rsp_data
);
   import appm_pkg::*;

   localparam logic [15:0] CoordMax = 16'((32'd1 << COORD_BITS) - 32'd1);

   // Parser and image state.
   logic [1:0]            magic_status_ff, magic_status_in;
   logic [1:0]            match_pos_ff, match_pos_in;
   logic                  in_token_ff, in_token_in;
   logic                  digits_ff, digits_in;
   logic                  skip_ff, skip_in;
   logic [15:0]           accum_ff, accum_in;
   logic [COORD_BITS-1:0] width_ff, width_in;
   logic [COORD_BITS-1:0] height_ff, height_in;
   logic [15:0]           max_level_ff, max_level_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [1:0]            channel_ff, channel_in;
   logic                  done_ff, done_in;

   // Divider and result.
   logic [DivBits-1:0]      rem_ff, rem_in;
   logic [DivBits-1:0]      shift_ff, shift_in;
   logic [DivSteps-1:0]     quot_ff, quot_in;
   logic [DivCountBits-1:0] count_ff, count_in;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   // Step scratch.
   logic [7:0]            byte_val;
   logic [7:0]            digit_diff;
   logic [19:0]           product;
   logic                  finish;
   logic [15:0]           value;
   logic                  result;
   logic                  divide;
   rsp_payload_type       res_data;
   logic [COORD_BITS:0]   column_next;
   logic [COORD_BITS:0]   row_next;
   logic                  chan_wrap;
   logic                  div_ge;
   logic [DivSteps-1:0]   quot_step;
   logic                  div_last;

   // Decode one byte against the current state.
   always_comb begin
      magic_status_in = magic_status_ff;
      match_pos_in    = match_pos_ff;
      in_token_in     = in_token_ff;
      digits_in       = digits_ff;
      skip_in         = skip_ff;
      accum_in        = accum_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      max_level_in    = max_level_ff;
      row_in          = row_ff;
      column_in       = column_ff;
      channel_in      = channel_ff;
      done_in         = done_ff;
      result          = 1'b0;
      divide          = 1'b0;
      res_data        = '0;
      finish          = 1'b0;
      value           = 16'h0000;
      product         = 20'h00000;
      column_next     = '0;
      row_next        = '0;
      chan_wrap       = 1'b0;
      byte_val        = req_data.data_byte;
      digit_diff      = byte_val - CharZero;

      priority if (skip_ff) begin
         if (byte_val == CharNewline) begin
            skip_in = 1'b0;
         end
      end else if (byte_val == CharHash) begin
         skip_in      = 1'b1;
         in_token_in  = 1'b0;
         digits_in    = 1'b0;
         accum_in     = 16'h0000;
         match_pos_in = PosNone;
      end else if (byte_val == CharSpace || byte_val == CharNewline) begin
         finish = 1'b1;
      end else begin
         // Open a token on its first byte.
         if (!in_token_in) begin
            in_token_in  = 1'b1;
            digits_in    = 1'b1;
            accum_in     = 16'h0000;
            match_pos_in = PosNone;
         end
         // Accumulate leading digits, saturating.
         if (byte_val >= CharZero && byte_val <= CharNine) begin
            if (digits_in) begin
               product = {1'b0, accum_in, 3'b000} + {3'b000, accum_in, 1'b0}
                         + {16'h0000, digit_diff[3:0]};
               accum_in = (product[19:16] != 4'h0) ? AccumMax : product[15:0];
            end
         end else begin
            digits_in = 1'b0;
         end
         // Track the magic token.
         if (magic_status_ff == MagicUnseen) begin
            if (match_pos_in == PosNone && byte_val == CharP) begin
               match_pos_in = PosP;
            end else if (match_pos_in == PosP && byte_val == CharThree) begin
               match_pos_in = PosP3;
            end else begin
               match_pos_in = PosMismatch;
            end
         end
      end

      if (req_data.end_of_stream) begin
         finish = 1'b1;
      end

      // Close the open token.
      if (finish && in_token_in) begin
         value       = accum_in;
         in_token_in = 1'b0;
         digits_in   = 1'b0;
         accum_in    = 16'h0000;
         priority if (magic_status_ff == MagicUnseen) begin
            magic_status_in = (match_pos_in == PosP3) ? MagicAccepted : MagicRejected;
            match_pos_in    = PosNone;
         end else if (magic_status_ff == MagicAccepted) begin
            result = 1'b1;
            priority if (width_ff == '0) begin
               width_in              = (value > CoordMax) ? CoordMax[COORD_BITS-1:0]
                                                          : value[COORD_BITS-1:0];
               res_data.kind         = KindWidth;
               res_data.header_value = 16'(width_in);
            end else if (height_ff == '0) begin
               height_in             = (value > CoordMax) ? CoordMax[COORD_BITS-1:0]
                                                          : value[COORD_BITS-1:0];
               res_data.kind         = KindHeight;
               res_data.header_value = 16'(height_in);
            end else if (max_level_ff == 16'h0000) begin
               max_level_in          = value;
               res_data.kind         = KindMaxval;
               res_data.header_value = value;
            end else if (done_ff) begin
               res_data.kind          = KindSample;
               res_data.overflow_drop = 1'b1;
            end else begin
               divide           = 1'b1;
               res_data.kind    = KindSample;
               res_data.row     = 16'(row_ff);
               res_data.column  = 16'(column_ff);
               res_data.channel = channel_ff;
               // Advance channel, column and row.
               chan_wrap   = (channel_ff == ChannelLast);
               channel_in  = chan_wrap ? 2'd0 : channel_ff + 2'd1;
               column_next = {1'b0, column_ff} + {{COORD_BITS{1'b0}}, chan_wrap};
               row_next    = {1'b0, row_ff};
               if (column_next >= {1'b0, width_ff}) begin
                  column_in = '0;
                  row_next  = {1'b0, row_ff} + {{COORD_BITS{1'b0}}, 1'b1};
               end else begin
                  column_in = column_next[COORD_BITS-1:0];
               end
               row_in = row_next[COORD_BITS-1:0];
               if (row_next >= {1'b0, height_ff}) begin
                  done_in             = 1'b1;
                  res_data.image_full = 1'b1;
               end
            end
         end else begin
            result = 1'b0;
         end
      end

      // End of stream drops any open token or comment.
      if (req_data.end_of_stream) begin
         in_token_in = 1'b0;
         digits_in   = 1'b0;
         skip_in     = 1'b0;
         accum_in    = 16'h0000;
      end
   end

   // One restoring divide step.
   always_comb begin
      div_ge    = (rem_ff >= shift_ff);
      quot_step = {quot_ff[DivSteps-2:0], div_ge};
      div_last  = (count_ff == DivCountBits'(DivSteps - 1));
   end

   // Divider and result register next values.
   always_comb begin
      rem_in      = rem_ff;
      shift_in    = shift_ff;
      quot_in     = quot_ff;
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.accept) begin
         if (result) begin
            rsp_data_in = res_data;
         end
         if (divide) begin
            // Dividend is value * 255, divisor starts at maxval shifted up by 8.
            rem_in   = {value, 8'h00} - {8'h00, value};
            shift_in = {max_level_ff, 8'h00};
            quot_in  = '0;
            count_in = '0;
         end
      end else if (cmd.div_run) begin
         rem_in   = div_ge ? (rem_ff - shift_ff) : rem_ff;
         shift_in = {1'b0, shift_ff[DivBits-1:1]};
         quot_in  = quot_step;
         count_in = count_ff + DivCountBits'(1);
         if (div_last) begin
            rsp_data_in.sample = quot_step[DivSteps-1] ? SampleMax
                                                       : quot_step[DivSteps-2:0];
         end
      end
   end

   // Hold parser state; change it only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_status_ff <= MagicUnseen;
         match_pos_ff    <= PosNone;
         in_token_ff     <= 1'b0;
         digits_ff       <= 1'b0;
         skip_ff         <= 1'b0;
         accum_ff        <= 16'h0000;
         width_ff        <= '0;
         height_ff       <= '0;
         max_level_ff    <= 16'h0000;
         row_ff          <= '0;
         column_ff       <= '0;
         channel_ff      <= 2'd0;
         done_ff         <= 1'b0;
         count_ff        <= '0;
      end else begin
         if (cmd.accept) begin
            magic_status_ff <= magic_status_in;
            match_pos_ff    <= match_pos_in;
            in_token_ff     <= in_token_in;
            digits_ff       <= digits_in;
            skip_ff         <= skip_in;
            accum_ff        <= accum_in;
            width_ff        <= width_in;
            height_ff       <= height_in;
            max_level_ff    <= max_level_in;
            row_ff          <= row_in;
            column_ff       <= column_in;
            channel_ff      <= channel_in;
            done_ff         <= done_in;
         end
         count_ff <= count_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      shift_ff    <= shift_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.result   = result;
   assign status.divide   = divide;
   assign status.div_last = div_last;
   assign rsp_data        = rsp_data_ff;

endmodule

FILE: rtl/core/appm_ctrl.sv
// Controller: accept handshake, divide sequencing and result valid.
`include "assert_macros.svh"

module appm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  appm_pkg::dp_status_type status,
   output appm_pkg::ctl_cmd_type   cmd
);
   import appm_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // Result slot is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (cmd.accept && status.divide) begin
               state_in = StDivide;
            end
         end
         StDivide: begin
            if (status.div_last) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_stall   = 1'b1;
      cmd.div_run = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_stall = reset || !out_free;
         end
         StDivide: begin
            cmd.div_run = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      cmd.accept = req_valid && !req_stall;
   end

   // Load the result beat, drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.accept && status.result && !status.divide) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.div_run && status.div_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `APPM_ASSERT(a_div_slot_empty, clock, reset, (state_ff == StDivide) |-> !rsp_valid_ff, "result slot busy while dividing")
   `APPM_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> ($past(cmd.accept) || $past(state_ff == StDivide)), "result beat without a source")
   `APPM_ASSERT(a_div_entry, clock, reset, (cmd.accept && status.divide) |=> (state_ff == StDivide), "sample did not start the divider")
   `APPM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!rsp_valid_ff && state_ff == StIdle), "reset left control state set")

endmodule

FILE: rtl/core/ascii_ppm_byte_decoder.sv
// ASCII P3 image byte decoder: top level joining controller and datapath.
// Results: a header result is valid the cycle after its ending byte is accepted;
// a pixel sample is valid once the divider has run its 9 steps after acceptance.
// Throughput: one byte per cycle while the result slot is free; a byte that ends a
// pixel sample holds the input while the shared bit-serial divider scales it.
// Reset: synchronous, clears parser, header and counter state; no byte is taken during reset.
module ascii_ppm_byte_decoder #(
   parameter int COORD_BITS = appm_pkg::CoordBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  appm_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output appm_pkg::rsp_payload_type rsp_data
);
   import appm_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequence the handshakes and divide steps.
   appm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Parse bytes, count pixels, scale samples.
   appm_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
